>>> design/control_char_escaper_defines.svh
// Assertion macros used by the checker of the escaper.
`ifndef CONTROL_CHAR_ESCAPER_DEFINES_SVH
`define CONTROL_CHAR_ESCAPER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define CCE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("control_char_escaper: same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off while in reset.
`define CCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("control_char_escaper: next-cycle check failed");

`endif

>>> design/cce_pkg.sv
package cce_pkg;

    localparam int RUN_MAX = 6;
    localparam int IDX_W   = $clog2(RUN_MAX);

    // escape_options bit positions
    localparam int OPT_UNICODE = 0;
    localparam int OPT_DQUOTE  = 1;
    localparam int OPT_SQUOTE  = 2;
    localparam int OPT_BSLASH  = 3;
    localparam int OPT_UTF8    = 4;
    localparam int OPT_W       = 5;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_VT     = 8'h0b;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CTRL_LIM  = 8'h20;
    localparam logic [7:0] UTF8_LEAD = 8'hc0;
    localparam logic [7:0] UTF8_CONT = 8'h80;
    localparam logic [7:0] LOW6_MASK = 8'h3f;

    typedef logic [RUN_MAX-1:0][7:0] t_seq;
    typedef logic [IDX_W-1:0]        t_idx;

    // One encoded run: bytes in order from element 0, plus index of its last byte.
    typedef struct packed {
        t_seq seq;
        t_idx last_idx;
    } t_run;

    // Lower-case hex digit of a nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        return (nib < 4'd10) ? (CH_ZERO + wide) : (CH_A - 8'd10 + wide);
    endfunction

endpackage

>>> design/cce_encoder.sv
module cce_encoder (
    input  logic [7:0]                i_byte,
    input  logic [cce_pkg::OPT_W-1:0] i_opts,
    output cce_pkg::t_run             o_run
);

    logic       esc_hit;
    logic [7:0] esc_chr;
    logic [7:0] hex_hi;
    logic [7:0] hex_lo;

    assign hex_hi = cce_pkg::hex_char(i_byte[7:4]);
    assign hex_lo = cce_pkg::hex_char(i_byte[3:0]);

    // Standard two-byte escapes.
    always_comb begin
        esc_hit = 1'b1;
        esc_chr = i_byte;
        unique case (i_byte)
            cce_pkg::CH_NUL: begin
                esc_hit = !i_opts[cce_pkg::OPT_UNICODE];
                esc_chr = cce_pkg::CH_ZERO;
            end
            cce_pkg::CH_DQUOTE: esc_hit = i_opts[cce_pkg::OPT_DQUOTE];
            cce_pkg::CH_SQUOTE: esc_hit = i_opts[cce_pkg::OPT_SQUOTE];
            cce_pkg::CH_BSLASH: esc_hit = i_opts[cce_pkg::OPT_BSLASH];
            cce_pkg::CH_BEL:    esc_chr = cce_pkg::CH_A;
            cce_pkg::CH_BS:     esc_chr = cce_pkg::CH_B;
            cce_pkg::CH_FF:     esc_chr = cce_pkg::CH_F;
            cce_pkg::CH_LF:     esc_chr = cce_pkg::CH_N;
            cce_pkg::CH_CR:     esc_chr = cce_pkg::CH_R;
            cce_pkg::CH_TAB:    esc_chr = cce_pkg::CH_T;
            cce_pkg::CH_VT:     esc_chr = cce_pkg::CH_V;
            default:            esc_hit = 1'b0;
        endcase
    end

    always_comb begin
        o_run.seq      = '0;
        o_run.last_idx = cce_pkg::t_idx'(0);
        priority if (esc_hit) begin
            o_run.seq[0]   = cce_pkg::CH_BSLASH;
            o_run.seq[1]   = esc_chr;
            o_run.last_idx = cce_pkg::t_idx'(1);
        end else if (i_opts[cce_pkg::OPT_UNICODE]) begin
            if (i_byte < cce_pkg::CTRL_LIM) begin
                o_run.seq[0]   = cce_pkg::CH_BSLASH;
                o_run.seq[1]   = cce_pkg::CH_U;
                o_run.seq[2]   = cce_pkg::CH_ZERO;
                o_run.seq[3]   = cce_pkg::CH_ZERO;
                o_run.seq[4]   = hex_hi;
                o_run.seq[5]   = hex_lo;
                o_run.last_idx = cce_pkg::t_idx'(5);
            end else begin
                o_run.seq[0]   = i_byte;
            end
        end else if (i_byte < cce_pkg::CTRL_LIM) begin
            o_run.seq[0]   = cce_pkg::CH_BSLASH;
            o_run.seq[1]   = cce_pkg::CH_X;
            o_run.seq[2]   = hex_hi;
            o_run.seq[3]   = hex_lo;
            o_run.last_idx = cce_pkg::t_idx'(3);
        end else if (i_byte[7] && i_opts[cce_pkg::OPT_UTF8]) begin
            o_run.seq[0]   = cce_pkg::UTF8_LEAD | {6'b0, i_byte[7:6]};
            o_run.seq[1]   = cce_pkg::UTF8_CONT | (i_byte & cce_pkg::LOW6_MASK);
            o_run.last_idx = cce_pkg::t_idx'(1);
        end else begin
            o_run.seq[0]   = i_byte;
        end
    end

endmodule

>>> design/cce_run_buf.sv
module cce_run_buf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load_valid,
    input  cce_pkg::t_run i_run,
    output logic          o_load_ready,
    output logic          o_tvalid,
    input  logic          i_tready,
    output logic [7:0]    o_tdata,
    output logic          o_tlast
);

    logic              r_valid;
    cce_pkg::t_run     r_run;
    cce_pkg::t_idx     r_idx;
    logic              out_take;

    assign o_tvalid     = r_valid;
    assign o_tdata      = r_run.seq[r_idx];
    assign o_tlast      = (r_idx == r_run.last_idx);
    assign out_take     = r_valid && i_tready;
    // free now, or the last byte of the held run leaves this cycle
    assign o_load_ready = !r_valid || (out_take && o_tlast);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_load_ready) begin
            r_valid <= i_load_valid;
            r_idx   <= '0;
        end else if (out_take) begin
            r_idx   <= r_idx + cce_pkg::t_idx'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load_ready && i_load_valid) begin
            r_run <= i_run;
        end
    end

endmodule

>>> design/control_char_escaper.sv
// Control character escaper. Each byte taken on s_axis becomes an escaped
// run of one to six bytes on m_axis, tlast marking the run's final byte:
// "\a" style escapes for BEL BS TAB LF VT FF CR, "\0" for NUL, "\xhh" or
// "\u00hh" for other control bytes, optional quote and backslash escapes,
// optional Latin-1 to UTF-8 re-encoding. escape_options (bit0 unicode,
// bit1 double quote, bit2 single quote, bit3 backslash, bit4 utf8) is
// written through the cfg port while the block is idle, which the user
// must ensure, as the block does not enforce it; reset clears it. A
// request is held in the input register, encoded combinationally and
// loaded into the run register, which offers the run's first byte on
// m_axis. The run register sends one byte per cycle while m_axis_tready
// is high; plain bytes stream at one per cycle when the output does not
// stall. The input register holds one more request while a run waits.
module control_char_escaper (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [4:0] i_cfg_data,      // escape_options
    // input bytes
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] in_byte
    // escaped bytes
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] out_byte
    output logic       m_axis_tlast     // run_last
);

    logic [cce_pkg::OPT_W-1:0] r_opts;
    logic                      r_in_valid;
    logic [7:0]                r_in_byte;
    logic                      n_in_valid;
    logic                      run_ready;
    cce_pkg::t_run             enc_run;

    // Configuration: always ready; the whole cfg word fills the register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opts <= '0;
        end else if (i_cfg_valid) begin
            r_opts <= i_cfg_data;
        end
    end

    // Input register: take a new request when empty or when its byte
    // moves into the run register this cycle.
    assign s_axis_tready = !r_in_valid || run_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (s_axis_tready) begin
            n_in_valid = s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // Payload: hold unless a request is taken.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // Encode the held byte into its whole run in one pass.
    cce_encoder u_encoder (
        .i_byte (r_in_byte),
        .i_opts (r_opts),
        .o_run  (enc_run)
    );

    // Run register: advance one byte per accepted output beat.
    cce_run_buf u_run_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_in_valid),
        .i_run        (enc_run),
        .o_load_ready (run_ready),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_tdata      (m_axis_tdata),
        .o_tlast      (m_axis_tlast)
    );

endmodule

>>> design/cce_checker.sv
`include "control_char_escaper_defines.svh"

module cce_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // A stalled output beat holds.
    `CCE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // A run never breaks off before its last byte.
    `CCE_ASSERT_NEXT(a_run_continues, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid)

    // With the output side empty, input must be open.
    `CCE_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)

    // Multi-byte runs open with a backslash or a UTF-8 lead byte.
    `CCE_ASSERT_NOW(a_run_head, m_axis_tvalid && !m_axis_tlast && !$past(m_axis_tvalid && !m_axis_tlast), m_axis_tdata == cce_pkg::CH_BSLASH || m_axis_tdata[7:6] == 2'b11)

endmodule

bind control_char_escaper cce_checker u_cce_checker (.*);

>>> bench/control_char_escaper_check.sv
// Watches the three channels of the escaper, predicts each escaped run and
// compares every output byte with the oldest expected one.
module control_char_escaper_check
    import cce_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [OPT_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [7:0]       i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [7:0]       i_out_data,
    input  logic             i_out_last,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_bytes_in,
    output int               o_bytes_out
);

    localparam logic [127:0] HEX_DIGITS = "0123456789abcdef";

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } esc_byte_t;

    esc_byte_t        expected_bytes[$];
    logic [OPT_W-1:0] opts_q;
    t_seq             run_bytes;
    int               run_len;
    esc_byte_t        want;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        return HEX_DIGITS[8 * (15 - int'(nib)) +: 8];
    endfunction

    // Escaped run of one byte under the given options; returns its length.
    function automatic int escape_byte(input logic [7:0] b, input logic [OPT_W-1:0] opts,
                                       output t_seq run);
        logic [7:0] letter;
        run    = '0;
        letter = 8'h00;
        case (b)
            CH_NUL:    if (!opts[OPT_UNICODE]) letter = CH_ZERO;
            CH_DQUOTE: if (opts[OPT_DQUOTE]) letter = b;
            CH_SQUOTE: if (opts[OPT_SQUOTE]) letter = b;
            CH_BSLASH: if (opts[OPT_BSLASH]) letter = b;
            CH_BEL:    letter = CH_A;
            CH_BS:     letter = CH_B;
            CH_FF:     letter = CH_F;
            CH_LF:     letter = CH_N;
            CH_CR:     letter = CH_R;
            CH_TAB:    letter = CH_T;
            CH_VT:     letter = CH_V;
            default:   letter = 8'h00;
        endcase
        if (letter != 8'h00) begin
            run[0] = CH_BSLASH;
            run[1] = letter;
            return 2;
        end
        if (b < CTRL_LIM && opts[OPT_UNICODE]) begin
            run[0] = CH_BSLASH;
            run[1] = CH_U;
            run[2] = CH_ZERO;
            run[3] = CH_ZERO;
            run[4] = hex_digit(b[7:4]);
            run[5] = hex_digit(b[3:0]);
            return 6;
        end
        if (b < CTRL_LIM) begin
            run[0] = CH_BSLASH;
            run[1] = CH_X;
            run[2] = hex_digit(b[7:4]);
            run[3] = hex_digit(b[3:0]);
            return 4;
        end
        // Latin-1 to UTF-8 applies only outside unicode mode
        if (b[7] && opts[OPT_UTF8] && !opts[OPT_UNICODE]) begin
            run[0] = UTF8_LEAD | {6'b0, b[7:6]};
            run[1] = UTF8_CONT | (b & LOW6_MASK);
            return 2;
        end
        run[0] = b;
        return 1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            opts_q = '0;
            expected_bytes.delete();
        end else begin
            // check output first so a byte never meets its own request
            if (i_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("byte %02h with nothing expected", i_out_data));
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out_data !== want.data)
                        report_mismatch($sformatf("byte %0d is %02h, expected %02h",
                                                  o_bytes_out, i_out_data, want.data));
                    if (i_out_last !== want.last)
                        report_mismatch($sformatf("byte %0d tlast is %b, expected %b",
                                                  o_bytes_out, i_out_last, want.last));
                end
                o_bytes_out++;
            end
            if (i_cfg_valid && i_cfg_ready)
                opts_q = i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                run_len = escape_byte(i_in_data, opts_q, run_bytes);
                for (int k = 0; k < run_len; k++)
                    expected_bytes.push_back('{data: run_bytes[k], last: (k == run_len - 1)});
                o_bytes_in++;
            end
        end
        o_pending = expected_bytes.size();
    end

endmodule

>>> bench/control_char_escaper_test.sv
// Stimulus and verdict for the escaper; all checking lives in the checker.
module control_char_escaper_test;
    import cce_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;   // quiet cycles before giving up
    localparam int SINK_HOLD      = 300;    // long receiver hold-off
    localparam int DRAIN_PAUSE    = 4;      // input reg + encode + run reg, with margin
    localparam int TAIL_CYCLES    = 8;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 50;

    localparam logic [OPT_W-1:0] OPTS_NONE      = '0;
    localparam logic [OPT_W-1:0] OPTS_ALL       = '1;
    localparam logic [OPT_W-1:0] OPTS_UTF8_ONLY = OPT_W'(1) << OPT_UTF8;
    localparam logic [OPT_W-1:0] OPTS_NO_UNI    = OPTS_ALL & ~(OPT_W'(1) << OPT_UNICODE);

    // every standard escape, control edges, quotes with options clear, top bytes
    localparam logic [7:0] PLAIN_SET [16] = '{
        CH_NUL, 8'h01, 8'h1f, CH_BEL, CH_BS, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR,
        CH_DQUOTE, CH_SQUOTE, CH_BSLASH, 8'h7f, 8'h80, 8'hff
    };
    // unicode with utf8: NUL as \u0000, quotes escaped, high bytes unchanged
    localparam logic [7:0] UNICODE_SET [8] = '{
        CH_NUL, 8'h1f, CH_DQUOTE, CH_SQUOTE, CH_BSLASH, 8'h80, 8'hff, CH_LF
    };
    // utf8 alone: high bytes become two-byte sequences
    localparam logic [7:0] UTF8_SET [2] = '{8'h80, 8'hff};

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [OPT_W-1:0] i_cfg_data;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [7:0]       m_axis_tdata;
    logic             m_axis_tlast;

    int fail_count;
    int pending_bytes;
    int bytes_in;
    int bytes_out;
    int settings_written;
    int src_idle_pct;
    int sink_idle_pct;
    int holds_asked;
    int holds_served;
    int quiet_cycles;
    logic [OPT_W-1:0] phase_opts;

    control_char_escaper dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    control_char_escaper_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_bytes),
        .o_bytes_in   (bytes_in),
        .o_bytes_out  (bytes_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: drop tready at random, or hold it low for a long stretch
    // when the stimulus asks, so the block backs up into its input.
    initial begin
        m_axis_tready = 1'b0;
        holds_served  = 0;
        forever begin
            @(negedge i_clk);
            if (holds_served != holds_asked) begin
                holds_served++;
                m_axis_tready <= 1'b0;
                repeat (SINK_HOLD - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Watchdog: end the run when no request of any channel goes through for too long.
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no request accepted for %0d cycles, %0d bytes still expected",
                 WATCHDOG_LIMIT, pending_bytes);
        $display("*** FAILED ***");
        $finish;
    end

    // Offer one byte, idling first at the sender's rate; return at the
    // falling edge after acceptance with tvalid still high.
    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Stop offering, wait for every expected byte, then let the pipe empty.
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (pending_bytes != 0) @(negedge i_clk);
        repeat (DRAIN_PAUSE) @(negedge i_clk);
    endtask

    task automatic write_options(input logic [OPT_W-1:0] value);
        settle_block();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        settings_written++;
    endtask

    // Bias toward control bytes, quote characters and the Latin-1 half.
    function automatic logic [7:0] pick_text_byte();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35)
            return 8'($urandom_range(31));
        if (roll < 50) begin
            case ($urandom_range(2))
                0:       return CH_DQUOTE;
                1:       return CH_SQUOTE;
                default: return CH_BSLASH;
            endcase
        end
        if (roll < 70)
            return 8'h80 | 8'($urandom_range(127));
        return 8'($urandom_range(255));
    endfunction

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_data       = '0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        settings_written = 0;
        holds_asked      = 0;
        src_idle_pct     = 35;
        sink_idle_pct    = 80;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, receiver-heavy idling
        write_options(OPTS_NONE);
        foreach (PLAIN_SET[i]) send_byte(PLAIN_SET[i]);
        write_options(OPTS_ALL);
        foreach (UNICODE_SET[i]) send_byte(UNICODE_SET[i]);
        write_options(OPTS_UTF8_ONLY);
        foreach (UTF8_SET[i]) send_byte(UTF8_SET[i]);

        // Random part: two phases per idling mode, options changed between phases
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       phase_opts = OPTS_NONE;
                1:       phase_opts = OPTS_ALL;
                4:       phase_opts = OPTS_NO_UNI;
                default: phase_opts = OPT_W'($urandom_range(31));
            endcase
            write_options(phase_opts);
            if (phase < 2) begin
                src_idle_pct  = 35;
                sink_idle_pct = 80;
            end else if (phase < 4) begin
                src_idle_pct  = 80;
                sink_idle_pct = 35;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            // hold the receiver off while the sender streams at full rate
            if (phase == 4)
                holds_asked++;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_byte(pick_text_byte());
        end

        settle_block();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("run covered %0d text bytes escaped into %0d output bytes under %0d settings",
                 bytes_in, bytes_out, settings_written);
        $display("idling on either side, none, and one long receiver hold with input stalled");
        if (fail_count == 0 && pending_bytes == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> control_char_escaper.f
+incdir+design
design/cce_pkg.sv
design/cce_encoder.sv
design/cce_run_buf.sv
design/control_char_escaper.sv
design/cce_checker.sv
bench/control_char_escaper_check.sv
bench/control_char_escaper_test.sv
